### hw/rtl/ssec_pkg.sv
package ssec_pkg;

  localparam int SUM_W      = 24;
  localparam int CNT_W      = 9;
  localparam int ANS_W      = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [CNT_W-1:0]     CNT_MAX        = '1;
  localparam logic [ANS_W-1:0]     ANS_MAX        = '1;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_SUM = '0;

  // One item as it travels down the chain of table cells.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic [SUM_W-1:0] sum;       // prefix sum after this element
    logic [SUM_W-1:0] key;       // sum minus target, looked up on the way
    logic [CNT_W-1:0] found;     // count of the entry that matched key
    logic             recorded;  // sum already counted or stored by a cell
  } ssec_pkt_t;

endpackage

### hw/rtl/ssec_cell.sv
module ssec_cell
  import ssec_pkg::*;
#(
  parameter bit IS_HEAD = 1'b0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  ssec_pkt_t pkt_i,
  output ssec_pkt_t pkt_o
);

  logic             vld_r, vld_nxt;
  logic [SUM_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  ssec_pkt_t        pkt_r, pkt_nxt;

  logic             b_vld;
  logic [SUM_W-1:0] b_key;
  logic [CNT_W-1:0] b_cnt;
  logic             hit_look, hit_rec;

  always_comb begin
    // A first item wipes the entry; the head cell holds the empty prefix.
    if (pkt_i.first) begin
      b_vld = IS_HEAD;
      b_key = '0;
      b_cnt = {{(CNT_W-1){1'b0}}, IS_HEAD};
    end else begin
      b_vld = vld_r;
      b_key = key_r;
      b_cnt = cnt_r;
    end

    hit_look = b_vld && (b_key == pkt_i.key);
    hit_rec  = b_vld && (b_key == pkt_i.sum);

    pkt_nxt = pkt_i;
    vld_nxt = b_vld;
    key_nxt = b_key;
    cnt_nxt = b_cnt;

    // Lookup sees the entry before this item's own record.
    if (hit_look) begin
      pkt_nxt.found = b_cnt;
    end

    if (!pkt_i.recorded) begin
      if (hit_rec) begin
        pkt_nxt.recorded = 1'b1;
        if (b_cnt != CNT_MAX) begin
          cnt_nxt = b_cnt + 1'b1;
        end
      end else if (!b_vld) begin
        pkt_nxt.recorded = 1'b1;
        vld_nxt = 1'b1;
        key_nxt = pkt_i.sum;
        cnt_nxt = {{(CNT_W-1){1'b0}}, 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= IS_HEAD;
      key_r       <= '0;
      cnt_r       <= {{(CNT_W-1){1'b0}}, IS_HEAD};
      pkt_r.valid <= 1'b0;
    end else if (adv) begin
      pkt_r <= pkt_nxt;
      if (pkt_i.valid) begin
        vld_r <= vld_nxt;
        key_r <= key_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  assign pkt_o = pkt_r;

endmodule

### hw/rtl/ssec_tail.sv
module ssec_tail
  import ssec_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  ssec_pkt_t        pkt_i,
  output logic             adv,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [ANS_W-1:0] out_tdata,
  output logic             out_tuser
);

  logic [ANS_W-1:0] ans_r, ans_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r;
  logic [ANS_W-1:0] out_ans_r;
  logic             out_ovf_r;
  logic             skid_valid_r;
  logic [ANS_W-1:0] skid_ans_r;
  logic             skid_ovf_r;
  logic [ANS_W:0]   acc;
  logic [ANS_W-1:0] base_ans;
  logic             push;

  assign adv  = !skid_valid_r;
  assign push = pkt_i.valid && adv;

  always_comb begin
    base_ans = pkt_i.first ? '0 : ans_r;
    acc      = {1'b0, base_ans} + {{(ANS_W+1-CNT_W){1'b0}}, pkt_i.found};
    ans_nxt  = acc[ANS_W] ? ANS_MAX : acc[ANS_W-1:0];
    ovf_nxt  = (pkt_i.first ? 1'b0 : ovf_r) | !pkt_i.recorded;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ans_r        <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (push) begin
        ans_r <= ans_nxt;
        ovf_r <= ovf_nxt;
      end
      if (!out_valid_r || out_tready) begin
        if (skid_valid_r) begin
          out_ans_r    <= skid_ans_r;
          out_ovf_r    <= skid_ovf_r;
          skid_valid_r <= 1'b0;
        end else if (push) begin
          out_ans_r   <= ans_nxt;
          out_ovf_r   <= ovf_nxt;
          out_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b0;
        end
      end else if (push) begin
        skid_ans_r   <= ans_nxt;
        skid_ovf_r   <= ovf_nxt;
        skid_valid_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_ans_r;
  assign out_tuser  = out_ovf_r;

endmodule

### hw/rtl/subarray_sum_equals_target_count_unit.sv
// Subarray-sum counter: counts contiguous runs of elements whose sum equals
// a programmed target, using a table of prefix sums and their occurrences.
// Input stream (in_*): one element per item; in_tuser set marks the first
// element of a new array and clears the table, prefix sum and answer.
// Output stream (out_*): one item per input item, the saturating match
// count so far and a sticky flag set when a new prefix sum found no room.
// Config (cfg_*): target_sum at byte address 0, written with psel, penable
// and pwrite high; pready is tied high. Write it only while the block idles.
// The table is a chain of MAX_ELEMENTS cells, one entry each; an item walks
// one cell per cycle, looking up sum minus target and recording its sum.
// Items follow each other in every cell, so each sees all earlier updates.
// Throughput: one item per cycle while in_tready is high. An item passes
// the launch register, every cell and the output register to out_tvalid.
// A two-entry output buffer lets the chain take one more item while a result
// waits; once both are full the chain holds and in_tready drops.
// Reset: table holds only the empty prefix, target zero, streams empty.
module subarray_sum_equals_target_count_unit
  import ssec_pkg::*;
#(
  parameter int MAX_ELEMENTS  = 256,
  parameter int ELEMENT_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // element_value in the low ELEMENT_WIDTH bits, zero padded
  input  logic [((ELEMENT_WIDTH+7)/8)*8-1:0] in_tdata,
  input  logic                              in_tuser,   // first_element
  input  logic                              in_tvalid,
  output logic                              in_tready,
  output logic [ANS_W-1:0]                  out_tdata,  // match_count
  output logic                              out_tuser,  // table_overflow
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]             cfg_paddr,
  input  logic [CFG_DATA_W-1:0]             cfg_pwdata,
  output logic [CFG_DATA_W-1:0]             cfg_prdata,
  output logic                              cfg_pready
);

  logic [SUM_W-1:0] target_r;
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] elem_ext;
  logic [SUM_W-1:0] sum_new;
  logic             adv;
  logic             in_fire;
  ssec_pkt_t        entry_r, entry_nxt;
  ssec_pkt_t        chain [MAX_ELEMENTS+1];

  // Config port: single register, no wait states.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1:2] == REG_TARGET_SUM)
                      ? {{(CFG_DATA_W-SUM_W){1'b0}}, target_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[CFG_ADDR_W-1:2] == REG_TARGET_SUM) begin
      target_r <= cfg_pwdata[SUM_W-1:0];
    end
  end

  // Sign-extend or truncate the element to the prefix-sum width.
  generate
    if (ELEMENT_WIDTH >= SUM_W) begin : g_elem_trunc
      assign elem_ext = in_tdata[SUM_W-1:0];
    end else begin : g_elem_sext
      assign elem_ext = {{(SUM_W-ELEMENT_WIDTH){in_tdata[ELEMENT_WIDTH-1]}},
                         in_tdata[ELEMENT_WIDTH-1:0]};
    end
  endgenerate

  assign in_tready = adv;
  assign in_fire   = in_tvalid && in_tready;
  assign sum_new   = (in_tuser ? '0 : sum_r) + elem_ext;

  always_comb begin
    entry_nxt          = '0;
    entry_nxt.valid    = in_tvalid;
    entry_nxt.first    = in_tuser;
    entry_nxt.sum      = sum_new;
    entry_nxt.key      = sum_new - target_r;
    entry_nxt.found    = '0;
    entry_nxt.recorded = 1'b0;
  end

  // Hold the running prefix sum; launch the item into the chain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r         <= '0;
      entry_r.valid <= 1'b0;
    end else if (adv) begin
      entry_r <= entry_nxt;
      if (in_fire) begin
        sum_r <= sum_new;
      end
    end
  end

  assign chain[0] = entry_r;

  generate
    for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
      ssec_cell #(
        .IS_HEAD (i == 0)
      ) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .pkt_i (chain[i]),
        .pkt_o (chain[i+1])
      );
    end
  endgenerate

  // Accumulate the answer, track overflow, buffer results.
  ssec_tail u_tail (
    .clk        (clk),
    .rst_n      (rst_n),
    .pkt_i      (chain[MAX_ELEMENTS]),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### hw/rtl/ssec_checker.sv
module ssec_checker
  import ssec_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [ANS_W-1:0] out_tdata,
  input logic             out_tuser,
  input logic             cfg_pready
);

  a_out_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_backpressure_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  a_stall_releases: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready && out_tready |=> in_tready)
    else $error("input still stalled after result taken");

  a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("config port inserted wait state");

endmodule

bind subarray_sum_equals_target_count_unit ssec_checker u_ssec_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_pready (cfg_pready)
);
